// File: rtl/core/cascaded_position_speed_pid_core_assert.svh
// Assertion macros shared by the servo core.
`ifndef CASCADED_POSITION_SPEED_PID_CORE_ASSERT_SVH
`define CASCADED_POSITION_SPEED_PID_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPSP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cpsp_pkg.sv
package cpsp_pkg;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] setpoint;
    logic signed [31:0] angle_fb;
    logic signed [31:0] rpm_fb;
  } cpsp_in_t;

  typedef struct packed {
    logic signed [31:0] speed_target;
    logic signed [31:0] drive;
  } cpsp_out_t;

  localparam logic CMD_POSITION = 1'b0;
  localparam logic CMD_SPEED    = 1'b1;

  localparam logic [2:0] REG_POS_KP    = 3'd0;
  localparam logic [2:0] REG_POS_KI    = 3'd1;
  localparam logic [2:0] REG_POS_KD    = 3'd2;
  localparam logic [2:0] REG_POS_LIMIT = 3'd3;
  localparam logic [2:0] REG_SPD_KP    = 3'd4;
  localparam logic [2:0] REG_SPD_KI    = 3'd5;
  localparam logic [2:0] REG_SPD_KD    = 3'd6;
  localparam logic [2:0] REG_SPD_LIMIT = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SUB,
    OP_D2,
    OP_MUL_FIRST,
    OP_MUL_ACC,
    OP_ACC,
    OP_OUT
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [15:0] gain;
    logic [30:0]        limit;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_D1,
    S_D2,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_SUM,
    S_OUT
  } seq_state_t;

endpackage

// File: rtl/core/cpsp_alu.sv
module cpsp_alu
  import cpsp_pkg::*;
(
  input  logic               clk,
  input  alu_req_t           req,
  output logic signed [31:0] result
);

  logic signed [47:0] prod;
  logic signed [49:0] sum;
  logic signed [47:0] mul;
  logic signed [49:0] diff;
  logic signed [49:0] diff2;
  logic signed [49:0] total;
  logic signed [31:0] total_sat;
  logic signed [31:0] lim_pos;
  logic signed [31:0] lim_neg;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    mul   = 48'(req.gain) * 48'(req.a);
    diff  = 50'(req.a) - 50'(req.b);
    diff2 = 50'(req.a) - (50'(req.b) <<< 1) + 50'(req.c);
    // The increment is the exact product sum floored to Q16.16.
    total     = 50'(req.a) + (sum >>> 8);
    total_sat = sat32(total);
    lim_pos   = signed'({1'b0, req.limit});
    lim_neg   = -lim_pos;
  end

  always_comb begin
    case (req.op)
      OP_SUB: result = sat32(diff);
      OP_D2:  result = sat32(diff2);
      OP_OUT: begin
        if (total_sat > lim_pos) begin
          result = lim_pos;
        end else if (total_sat < lim_neg) begin
          result = lim_neg;
        end else begin
          result = total_sat;
        end
      end
      default: result = '0;
    endcase
  end

  // The product register splits the multiplier from the accumulating adder.
  always_ff @(posedge clk) begin
    case (req.op)
      OP_MUL_FIRST: begin
        prod <= mul;
        sum  <= '0;
      end
      OP_MUL_ACC: begin
        prod <= mul;
        sum  <= sum + 50'(prod);
      end
      OP_ACC: sum <= sum + 50'(prod);
      default: ;
    endcase
  end

endmodule

// File: rtl/core/cascaded_position_speed_pid_core.sv
// Channel  | Direction | Handshake            | Payload
// req      | in        | req_valid, req_stall | cpsp_in_t  (cmd, setpoint, angle_fb, rpm_fb)
// rsp      | out       | rsp_valid, rsp_stall | cpsp_out_t (speed_target, drive)
// cfg      | in        | cfg_we               | cfg_index, cfg_data
//
// Each loop steps through the error, difference, product, sum and output states on
// the shared multiply-accumulate unit; a position tick runs both loops, a speed
// tick the speed loop. The result sits in an output register, so a new request
// is taken while it waits; a stalled result holds the last step of the next tick.
// Synchronous reset clears gains, limits, error history and accumulators.
module cascaded_position_speed_pid_core
  import cpsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  cpsp_in_t    req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output cpsp_out_t   rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  `include "cascaded_position_speed_pid_core_assert.svh"

  seq_state_t state, state_next;
  logic       lp;           // 0 while the position loop runs, 1 for the speed loop
  logic       cmd_mode;
  logic       out_ok;

  logic signed [15:0] pos_kp, pos_ki, pos_kd, spd_kp, spd_ki, spd_kd;
  logic [30:0]        pos_out_limit, spd_out_limit;

  logic signed [31:0] pos_err_last, pos_err_before, pos_accum;
  logic signed [31:0] spd_err_last, spd_err_before, spd_accum;

  logic signed [31:0] setpoint_q, angle_q, rpm_q;
  logic signed [31:0] err, d1, d2;

  logic signed [31:0] ref_v, fdb_v, e1_v, e2_v, acc_v;
  logic signed [15:0] kp_v, ki_v, kd_v;
  logic [30:0]        lim_v;

  alu_req_t           alu_req;
  logic signed [31:0] alu_y;

  cpsp_alu u_alu (
    .clk    (clk),
    .req    (alu_req),
    .result (alu_y)
  );

  assign req_stall = (state != S_IDLE);
  // The speed loop result needs the output register free before it commits.
  assign out_ok = !lp || !rsp_valid || !rsp_stall;

  always_comb begin
    if (lp) begin
      ref_v = (cmd_mode == CMD_SPEED) ? setpoint_q : pos_accum;
      fdb_v = rpm_q;
      e1_v  = spd_err_last;
      e2_v  = spd_err_before;
      acc_v = spd_accum;
      kp_v  = spd_kp;
      ki_v  = spd_ki;
      kd_v  = spd_kd;
      lim_v = spd_out_limit;
    end else begin
      ref_v = setpoint_q;
      fdb_v = angle_q;
      e1_v  = pos_err_last;
      e2_v  = pos_err_before;
      acc_v = pos_accum;
      kp_v  = pos_kp;
      ki_v  = pos_ki;
      kd_v  = pos_kd;
      lim_v = pos_out_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    alu_req       = '0;
    alu_req.op    = OP_NOP;
    alu_req.limit = lim_v;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        alu_req.op = OP_SUB;
        alu_req.a  = ref_v;
        alu_req.b  = fdb_v;
        state_next = S_D1;
      end
      S_D1: begin
        alu_req.op = OP_SUB;
        alu_req.a  = err;
        alu_req.b  = e1_v;
        state_next = S_D2;
      end
      S_D2: begin
        alu_req.op = OP_D2;
        alu_req.a  = err;
        alu_req.b  = e1_v;
        alu_req.c  = e2_v;
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        alu_req.op   = OP_MUL_FIRST;
        alu_req.a    = d1;
        alu_req.gain = kp_v;
        state_next   = S_MUL_I;
      end
      S_MUL_I: begin
        alu_req.op   = OP_MUL_ACC;
        alu_req.a    = err;
        alu_req.gain = ki_v;
        state_next   = S_MUL_D;
      end
      S_MUL_D: begin
        alu_req.op   = OP_MUL_ACC;
        alu_req.a    = d2;
        alu_req.gain = kd_v;
        state_next   = S_SUM;
      end
      S_SUM: begin
        alu_req.op = OP_ACC;
        state_next = S_OUT;
      end
      S_OUT: begin
        alu_req.op = OP_OUT;
        alu_req.a  = acc_v;
        if (out_ok) begin
          state_next = lp ? S_IDLE : S_ERR;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control, configuration and loop history.
  always_ff @(posedge clk) begin
    if (rst) begin
      lp             <= 1'b0;
      cmd_mode       <= CMD_POSITION;
      rsp_valid      <= 1'b0;
      pos_kp         <= '0;
      pos_ki         <= '0;
      pos_kd         <= '0;
      pos_out_limit  <= '0;
      spd_kp         <= '0;
      spd_ki         <= '0;
      spd_kd         <= '0;
      spd_out_limit  <= '0;
      pos_err_last   <= '0;
      pos_err_before <= '0;
      pos_accum      <= '0;
      spd_err_last   <= '0;
      spd_err_before <= '0;
      spd_accum      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POS_KP:    pos_kp        <= cfg_data[15:0];
          REG_POS_KI:    pos_ki        <= cfg_data[15:0];
          REG_POS_KD:    pos_kd        <= cfg_data[15:0];
          REG_POS_LIMIT: pos_out_limit <= cfg_data;
          REG_SPD_KP:    spd_kp        <= cfg_data[15:0];
          REG_SPD_KI:    spd_ki        <= cfg_data[15:0];
          REG_SPD_KD:    spd_kd        <= cfg_data[15:0];
          REG_SPD_LIMIT: spd_out_limit <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_IDLE && req_valid) begin
        lp       <= req.cmd;
        cmd_mode <= req.cmd;
      end

      if (state == S_OUT && out_ok) begin
        if (lp) begin
          spd_accum      <= alu_y;
          spd_err_before <= spd_err_last;
          spd_err_last   <= err;
        end else begin
          pos_accum      <= alu_y;
          pos_err_before <= pos_err_last;
          pos_err_last   <= err;
          lp             <= 1'b1;
        end
      end

      if (state == S_OUT && lp && out_ok) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers and the output register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      setpoint_q <= req.setpoint;
      angle_q    <= req.angle_fb;
      rpm_q      <= req.rpm_fb;
    end
    case (state)
      S_ERR: err <= alu_y;
      S_D1:  d1  <= alu_y;
      S_D2:  d2  <= alu_y;
      default: ;
    endcase
    if (state == S_OUT && lp && out_ok) begin
      rsp.speed_target <= pos_accum;
      rsp.drive        <= alu_y;
    end
  end

  `CPSP_ASSERT_NEXT(a_start_loop, req_valid && !req_stall,
                    state == S_ERR && lp == $past(req.cmd),
                    "request transfer did not start the selected loop")
  `CPSP_ASSERT_NEXT(a_pos_hold, lp, $stable(pos_accum),
                    "position accumulator changed while the speed loop ran")
  `CPSP_ASSERT_SAME(a_rsp_source, $rose(rsp_valid), $past(state == S_OUT && lp),
                    "result appeared without a finished speed loop")

endmodule
